/* sv/rrta_pkg.sv */
// ----------------------------------------------------------------------------
// rrta_pkg
// Shared widths, codes and word types of the ring road traffic automaton.
// ----------------------------------------------------------------------------
package rrta_pkg;

  localparam int IDX_FIELD_W = 6;
  localparam int SPEED_W     = 4;
  localparam int CELL_W      = 2 * SPEED_W;
  localparam int TDATA_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int LEN_REG_W   = 7;
  localparam int THR_W       = 17;
  localparam int SEED_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROAD_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAWDLE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED      = 2'd2;

  localparam logic [LEN_REG_W-1:0] ROAD_LENGTH_RESET = 7'd64;
  localparam logic [THR_W-1:0]     THRESHOLD_RESET   = 17'd0;
  localparam logic [SEED_W-1:0]    LFSR_RESET        = 16'd1;
  localparam logic [SEED_W-1:0]    LFSR_TAPS         = 16'hB400;

  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_CLEAR,
    CMD_ECHO,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [IDX_FIELD_W-1:0]   index;
    logic [SPEED_W-1:0]       speed;
    logic [SPEED_W-1:0]       limit;
  } rrta_cmd_t;

  typedef struct packed {
    logic [LEN_REG_W-1:0] road_length;
    logic [THR_W-1:0]     dawdle_threshold;
    logic                 seed_load;
    logic [SEED_W-1:0]    seed;
  } rrta_cfg_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] index;
    logic                   occupied;
    logic [SPEED_W-1:0]     speed;
    logic                   last;
    logic                   error;
  } rrta_res_t;

endpackage

/* sv/rrta_ram.sv */
// ----------------------------------------------------------------------------
// rrta_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rrta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rrta_front.sv */
// ----------------------------------------------------------------------------
// rrta_front
// Input stage: takes words, saturates limits, classifies loads and ticks.
// ----------------------------------------------------------------------------
module rrta_front #(
  parameter int ROAD_CELLS = 64,
  parameter int SPEED_MAX  = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rrta_pkg::TDATA_W-1:0]   s_tdata,
  input  logic                           s_tuser,
  output logic                           q_push,
  output rrta_pkg::rrta_cmd_t            q_data,
  input  logic                           q_full
);

  import rrta_pkg::*;

  logic                   cmd_valid;
  rrta_cmd_t              cmd;
  rrta_cmd_t              cmd_next;
  logic [IDX_FIELD_W-1:0] in_idx;
  logic                   in_occ;
  logic [SPEED_W-1:0]     in_spd;
  logic [SPEED_W-1:0]     in_lim;
  logic [SPEED_W-1:0]     lim_sat;
  logic                   in_range;
  logic                   accept;

  assign in_idx = s_tdata[IDX_FIELD_W-1:0];
  assign in_occ = s_tdata[IDX_FIELD_W];
  assign in_spd = s_tdata[IDX_FIELD_W+SPEED_W:IDX_FIELD_W+1];
  assign in_lim = s_tdata[IDX_FIELD_W+2*SPEED_W:IDX_FIELD_W+SPEED_W+1];

  assign lim_sat  = (in_lim > SPEED_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : in_lim;
  assign in_range = ({1'b0, in_idx} < (IDX_FIELD_W + 1)'(ROAD_CELLS));

  always_comb begin
    cmd_next.index = in_idx;
    cmd_next.speed = in_spd;
    cmd_next.limit = lim_sat;
    if (s_tuser == MODE_TICK) begin
      cmd_next.kind = CMD_TICK;
    end else if (!in_range) begin
      cmd_next.kind = CMD_ECHO;
    end else if (!in_occ) begin
      cmd_next.kind = CMD_CLEAR;
    end else if (in_spd > lim_sat) begin
      cmd_next.kind = CMD_REJECT;
    end else begin
      cmd_next.kind = CMD_WRITE;
    end
  end

  assign s_tready = !cmd_valid || !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = cmd_valid && !q_full;
  assign q_data   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (q_push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* sv/rrta_fifo.sv */
// ----------------------------------------------------------------------------
// rrta_fifo
// Command queue between the input stage and the road engine.
// ----------------------------------------------------------------------------
module rrta_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rrta_pkg::rrta_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output rrta_pkg::rrta_cmd_t head,
  output logic                empty
);

  import rrta_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rrta_cmd_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/rrta_back.sv */
// ----------------------------------------------------------------------------
// rrta_back
// Road engine: executes loads and runs the four-pass update sweep.
// ----------------------------------------------------------------------------
module rrta_back #(
  parameter int ROAD_CELLS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rrta_pkg::rrta_cfg_t cfg,
  input  logic                q_empty,
  input  rrta_pkg::rrta_cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  output rrta_pkg::rrta_res_t out_res,
  input  logic                out_ready
);

  import rrta_pkg::*;

  localparam int IDX_W = $clog2(ROAD_CELLS);
  localparam int LEN_W = $clog2(ROAD_CELLS + 1);
  localparam int POS_W = $clog2(2 * ROAD_CELLS + (1 << SPEED_W));

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_GAP_RD,
    S_GAP_EX,
    S_DAW_RD,
    S_DAW_EX,
    S_MOVE,
    S_OUT_RD,
    S_OUT_EX
  } state_t;

  state_t                  state;
  logic [IDX_W-1:0]        idx;
  logic [POS_W-1:0]        nextpos;
  logic [POS_W-1:0]        tgt;
  logic [SPEED_W-1:0]      cur_spd;
  logic [SPEED_W-1:0]      cur_lim;
  logic [SEED_W-1:0]       lfsr;
  logic [ROAD_CELLS-1:0]   valid;
  logic [ROAD_CELLS-1:0]   nvalid;

  logic [LEN_W-1:0]        len;
  logic [IDX_W-1:0]        last_idx;
  logic                    at_last;
  logic                    out_free;

  logic                    cell_we;
  logic [IDX_W-1:0]        cell_waddr;
  logic [CELL_W-1:0]       cell_wdata;
  logic [CELL_W-1:0]       cell_rdata;
  logic                    next_we;
  logic [CELL_W-1:0]       next_rdata;

  logic [SPEED_W-1:0]      rd_spd;
  logic [SPEED_W-1:0]      rd_lim;
  logic [SPEED_W-1:0]      va;
  logic [POS_W-1:0]        gap;
  logic                    lone;
  logic [SPEED_W-1:0]      vn;
  logic [SEED_W-1:0]       lfsr_step;
  logic [SPEED_W-1:0]      vd;
  logic                    tgt_wraps;
  logic [IDX_W-1:0]        ld_addr;

  always_comb begin
    if (cfg.road_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg.road_length) > ROAD_CELLS) begin
      len = LEN_W'(ROAD_CELLS);
    end else begin
      len = cfg.road_length[LEN_W-1:0];
    end
  end

  assign last_idx = IDX_W'(len - LEN_W'(1));
  assign at_last  = (idx == last_idx);
  assign out_free = !out_valid || out_ready;
  assign ld_addr  = q_head.index[IDX_W-1:0];

  assign rd_spd = cell_rdata[CELL_W-1:SPEED_W];
  assign rd_lim = cell_rdata[SPEED_W-1:0];

  // accelerate, then hold back to the free gap unless the car is alone
  assign va   = (rd_spd < rd_lim) ? rd_spd + SPEED_W'(1) : rd_spd;
  assign gap  = nextpos - POS_W'(idx);
  assign lone = (gap == POS_W'(len));
  assign vn   = (!lone && (POS_W'(va) >= gap)) ? SPEED_W'(gap - POS_W'(1)) : va;

  assign lfsr_step = {1'b0, lfsr[SEED_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
  assign vd = (({1'b0, lfsr_step} < cfg.dawdle_threshold) && (rd_spd != '0))
              ? rd_spd - SPEED_W'(1) : rd_spd;

  assign tgt_wraps = (tgt >= POS_W'(len));

  assign q_pop = (state == S_IDLE) && !q_empty && ((q_head.kind == CMD_TICK) || out_free);

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = idx;
    cell_wdata = {rd_spd, rd_lim};
    next_we    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_pop && (q_head.kind == CMD_WRITE)) begin
          cell_we    = 1'b1;
          cell_waddr = ld_addr;
          cell_wdata = {q_head.speed, q_head.limit};
        end
      end
      S_GAP_EX: begin
        if (valid[idx]) begin
          cell_we    = 1'b1;
          cell_wdata = {vn, rd_lim};
        end
      end
      S_MOVE: begin
        next_we = !tgt_wraps;
      end
      S_OUT_EX: begin
        if (out_free) begin
          cell_we    = 1'b1;
          cell_wdata = next_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  rrta_ram #(
    .WIDTH(CELL_W),
    .DEPTH(ROAD_CELLS)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .raddr(idx),
    .rdata(cell_rdata)
  );

  rrta_ram #(
    .WIDTH(CELL_W),
    .DEPTH(ROAD_CELLS)
  ) u_next_ram (
    .clk  (clk),
    .we   (next_we),
    .waddr(tgt[IDX_W-1:0]),
    .wdata({cur_spd, cur_lim}),
    .raddr(idx),
    .rdata(next_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      lfsr      <= LFSR_RESET;
      valid     <= '0;
      nvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            // a tick may start while the last echo still waits
            if (q_head.kind != CMD_TICK) begin
              out_res.index    <= q_head.index;
              out_res.last     <= 1'b1;
              out_res.occupied <= 1'b0;
              out_res.speed    <= '0;
              out_res.error    <= 1'b0;
            end
            unique case (q_head.kind)
              CMD_TICK: begin
                idx   <= '0;
                state <= S_FIND;
              end
              CMD_WRITE: begin
                valid[ld_addr]   <= 1'b1;
                out_res.occupied <= 1'b1;
                out_res.speed    <= q_head.speed;
                out_valid        <= 1'b1;
              end
              CMD_CLEAR: begin
                valid[ld_addr] <= 1'b0;
                out_valid      <= 1'b1;
              end
              CMD_REJECT: begin
                out_res.error <= 1'b1;
                out_valid     <= 1'b1;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_FIND: begin
          // first car from the start of the road, seen by cars near the end
          if (valid[idx] || at_last) begin
            nextpos <= POS_W'(idx) + POS_W'(len);
            idx     <= last_idx;
            state   <= S_GAP_RD;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_GAP_RD: begin
          state <= S_GAP_EX;
        end
        S_GAP_EX: begin
          if (valid[idx]) begin
            nextpos <= POS_W'(idx);
          end
          if (idx == '0) begin
            nvalid <= '0;
            state  <= S_DAW_RD;
          end else begin
            idx   <= idx - IDX_W'(1);
            state <= S_GAP_RD;
          end
        end
        S_DAW_RD: begin
          state <= S_DAW_EX;
        end
        S_DAW_EX: begin
          if (valid[idx]) begin
            lfsr    <= lfsr_step;
            cur_spd <= vd;
            cur_lim <= rd_lim;
            tgt     <= POS_W'(idx) + POS_W'(vd);
            state   <= S_MOVE;
          end else if (at_last) begin
            idx   <= '0;
            state <= S_OUT_RD;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_DAW_RD;
          end
        end
        S_MOVE: begin
          if (tgt_wraps) begin
            tgt <= tgt - POS_W'(len);
          end else begin
            nvalid[tgt[IDX_W-1:0]] <= 1'b1;
            if (at_last) begin
              idx   <= '0;
              state <= S_OUT_RD;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_DAW_RD;
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_EX;
        end
        S_OUT_EX: begin
          if (out_free) begin
            valid[idx]       <= nvalid[idx];
            out_res.index    <= IDX_FIELD_W'(idx);
            out_res.occupied <= nvalid[idx];
            out_res.speed    <= nvalid[idx] ? next_rdata[CELL_W-1:SPEED_W] : '0;
            out_res.last     <= at_last;
            out_res.error    <= 1'b0;
            out_valid        <= 1'b1;
            if (at_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg.seed_load) begin
        lfsr <= (cfg.seed == '0) ? LFSR_RESET : cfg.seed;
      end
    end
  end

endmodule

/* sv/ring_road_traffic_automaton_core.sv */
// ----------------------------------------------------------------------------
// ring_road_traffic_automaton_core
// Circular-road traffic cellular automaton with load and tick commands.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per command. s_tuser selects load or tick.
// A load returns one echo word with m_tlast set; it writes its cell when
// in range and not rejected. m_tuser flags a load whose speed exceeds its
// limit. A tick returns one word per cell in use, m_tlast on the final cell.
// Words pass an input register and a command queue before the engine,
// so commands are taken while the engine is busy or the output stalls,
// until the queue is full. A load echo leaves from the engine's output
// register once the engine is idle and the output is free. A tick runs
// four passes over the cell RAM with registered reads: first-car search,
// gap pass, dawdle and move (targets past the end of short roads wrap
// again by the length), copy-back and report, one word per cell.
// A stalled receiver freezes the engine at the next output word; nothing
// is dropped. Reset empties every cell, clears the queue, sets the LFSR
// to one and the road length to its maximum.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ring_road_traffic_automaton_core #(
  parameter int ROAD_CELLS  = 64,
  parameter int SPEED_MAX   = 15,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cell_index[5:0], occupied[6], car_speed[10:7], car_limit[14:11]
  input  logic [rrta_pkg::TDATA_W-1:0]     s_tdata,
  // mode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_index[5:0], out_occupied[6], out_speed[10:7]
  output logic [rrta_pkg::TDATA_W-1:0]     m_tdata,
  output logic                             m_tlast,
  // error_code
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [rrta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrta_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rrta_pkg::*;

  logic [LEN_REG_W-1:0] road_length;
  logic [THR_W-1:0]     dawdle_threshold;
  rrta_cfg_t            cfg;
  logic                 q_push;
  rrta_cmd_t            q_data;
  logic                 q_full;
  logic                 q_pop;
  rrta_cmd_t            q_head;
  logic                 q_empty;
  rrta_res_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      road_length      <= ROAD_LENGTH_RESET;
      dawdle_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROAD_LENGTH) begin
        road_length <= cfg_data[LEN_REG_W-1:0];
      end
      if (cfg_index == CFG_DAWDLE_THRESHOLD) begin
        dawdle_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  assign cfg.road_length      = road_length;
  assign cfg.dawdle_threshold = dawdle_threshold;
  assign cfg.seed_load        = cfg_we && (cfg_index == CFG_RANDOM_SEED);
  assign cfg.seed             = cfg_data[SEED_W-1:0];

  rrta_front #(
    .ROAD_CELLS(ROAD_CELLS),
    .SPEED_MAX (SPEED_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full)
  );

  rrta_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  rrta_back #(
    .ROAD_CELLS(ROAD_CELLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_res  (res),
    .out_ready(m_tready)
  );

  assign m_tdata = {(TDATA_W - IDX_FIELD_W - 1 - SPEED_W)'(0), res.speed, res.occupied,
                    res.index};
  assign m_tlast = res.last;
  assign m_tuser = res.error;

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && !m_tdata[IDX_FIELD_W])
    else $error("error word must be a final, empty echo");

  a_empty_no_speed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[IDX_FIELD_W] |-> m_tdata[IDX_FIELD_W+SPEED_W:IDX_FIELD_W+1] == '0)
    else $error("empty cell reported with nonzero speed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty && (!m_tvalid || m_tready || q_head.kind == CMD_TICK))
    else $error("command taken from empty queue or into a full output");

endmodule
